// ===== rtl/psu_pkg.sv =====
// Package holding the types and constants of the particle swarm update core.
package psu_pkg;

  localparam int SwarmSizeDef = 32;
  localparam int IdxW         = 5;
  localparam int ValW         = 32;
  localparam int GainW        = 16;
  localparam int CfgIdxW      = 3;

  localparam logic signed [ValW-1:0] FitMax      = 32'sh7FFF_FFFF;
  localparam logic [GainW-1:0]       InertiaRst  = 16'd6554;
  localparam logic [GainW-1:0]       CogGainRst  = 16'd16384;
  localparam logic [GainW-1:0]       SocGainRst  = 16'd16384;
  localparam logic signed [ValW-1:0] LowerRst    = 32'sd0;
  localparam logic signed [ValW-1:0] UpperRst    = 32'sd524288;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_FITNESS   = 2'd1,
    ACT_MOVE      = 2'd2,
    ACT_NEW_ROUND = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INERTIA = 3'd0,
    CFG_COG     = 3'd1,
    CFG_SOC     = 3'd2,
    CFG_LOWER   = 3'd3,
    CFG_UPPER   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e                  action;
    logic [IdxW-1:0]          particle_index;
    logic signed [ValW-1:0]   start_position;
    logic signed [ValW-1:0]   fitness;
    logic [GainW-1:0]         rand_cognitive;
    logic [GainW-1:0]         rand_social;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]          out_index;
    logic signed [ValW-1:0]   out_position;
    logic [IdxW-1:0]          best_index;
    logic signed [ValW-1:0]   best_position;
    logic signed [ValW-1:0]   best_fitness;
  } out_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] pos;
    logic signed [ValW-1:0] vel;
    logic signed [ValW-1:0] obp;
    logic signed [ValW-1:0] obf;
    logic signed [ValW-1:0] lat;
  } entry_t;

endpackage

// ===== rtl/particle_swarm_update.sv =====
// Top level of the one-dimensional particle swarm update core.
//
//   channel   direction  handshake                 word
//   in        input      in_valid_i / in_stall_o   in_word_t
//   out       output     out_valid_o / out_stall_i out_word_t
//   cfg       input      cfg_valid_i / cfg_ready_o register index and data
//
// Load, fitness and new-round words take 3 cycles from acceptance until the next word can be
// accepted; a move word takes 5, set by the read of the particle memory, the product stage,
// the sum stage and the write-back. The result word waits in an output register, so the
// next word is taken while it is stalled; a second finished result waits until it drains.
// Reset clears the controller, the configuration and the round best; the particle memory
// needs no clearing pass.
module particle_swarm_update
  import psu_pkg::*;
#(
  parameter int SWARM_SIZE = SwarmSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ValW-1:0]     cfg_data_i
);

  localparam int AW = (SWARM_SIZE > 1) ? $clog2(SWARM_SIZE) : 1;

  state_e state_q, state_d;

  logic [GainW-1:0]       w_q, c1_q, c2_q;
  logic signed [ValW-1:0] lb_q, ub_q;

  entry_t particle_mem [SWARM_SIZE];
  entry_t rd_q;
  entry_t ent_q, ent_d, ent_new;

  in_word_t req_q;
  logic     req_ok_q;
  logic     in_ok;
  logic     accept;
  logic     mem_we;

  logic signed [ValW-1:0] rb_fit_q, rb_fit_d;
  logic [IdxW-1:0]        rb_idx_q, rb_idx_d;
  logic signed [ValW-1:0] rb_pos_q, rb_pos_d;

  logic signed [ValW:0]   d1_q, d2_q;
  logic [GainW-1:0]       k1_q, k2_q;
  logic [2*GainW-1:0]     k1_full, k2_full;
  logic signed [48:0]     p0_q;
  logic signed [49:0]     p1_q, p2_q;
  logic signed [51:0]     acc;
  logic signed [37:0]     acc_sh;
  logic signed [ValW-1:0] nv_d, nv_q;
  logic signed [ValW:0]   np;
  logic signed [ValW:0]   np_lo;
  logic signed [ValW-1:0] np_clamp;

  out_word_t res_d, res_q;
  out_word_t out_q;
  logic      out_valid_q;
  logic      out_free;
  logic      out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ok  = 32'(in_data_i.particle_index) < SWARM_SIZE;
  assign accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_READ;
      end
      ST_READ: begin
        if (req_q.action == ACT_MOVE && req_ok_q) state_d = ST_MUL;
        else state_d = ST_WB;
      end
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_WB;
      ST_WB: begin
        state_d = out_free ? ST_IDLE : ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_we     = (state_q == ST_WB) && req_ok_q && (req_q.action != ACT_NEW_ROUND);
    out_load   = ((state_q == ST_WB) || (state_q == ST_DONE)) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= InertiaRst;
      c1_q <= CogGainRst;
      c2_q <= SocGainRst;
      lb_q <= LowerRst;
      ub_q <= UpperRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INERTIA: w_q  <= cfg_data_i[GainW-1:0];
        CFG_COG:     c1_q <= cfg_data_i[GainW-1:0];
        CFG_SOC:     c2_q <= cfg_data_i[GainW-1:0];
        CFG_LOWER:   lb_q <= $signed(cfg_data_i);
        CFG_UPPER:   ub_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_ok) begin
      rd_q <= particle_mem[AW'(in_data_i.particle_index)];
    end
    if (mem_we) begin
      particle_mem[AW'(req_q.particle_index)] <= ent_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ok_q <= 1'b0;
    end else if (accept) begin
      req_ok_q <= in_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
  end

  // The personal best is refreshed from the latest fitness before the move uses it.
  always_comb begin
    ent_d = rd_q;
    if (req_q.action == ACT_MOVE && rd_q.lat < rd_q.obf) begin
      ent_d.obf = rd_q.lat;
      ent_d.obp = rd_q.pos;
    end
  end

  assign k1_full = req_q.rand_cognitive * c1_q;
  assign k2_full = req_q.rand_social * c2_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      ent_q <= ent_d;
      d1_q  <= 33'(ent_d.obp) - 33'(ent_d.pos);
      d2_q  <= 33'(rb_pos_q) - 33'(ent_d.pos);
      k1_q  <= k1_full[2*GainW-1:GainW];
      k2_q  <= k2_full[2*GainW-1:GainW];
    end
    if (state_q == ST_MUL) begin
      p0_q <= ent_q.vel * $signed({1'b0, w_q});
      p1_q <= d1_q * $signed({1'b0, k1_q});
      p2_q <= d2_q * $signed({1'b0, k2_q});
    end
    if (state_q == ST_SUM) begin
      nv_q <= nv_d;
    end
  end

  // Arithmetic shift rounds toward minus infinity; the sum then saturates to 32 bits.
  always_comb begin
    acc    = 52'(p0_q) + 52'(p1_q) + 52'(p2_q);
    acc_sh = acc[51:14];
    if (acc_sh[37:31] == {7{acc_sh[37]}}) begin
      nv_d = acc_sh[31:0];
    end else if (acc_sh[37]) begin
      nv_d = 32'sh8000_0000;
    end else begin
      nv_d = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    np       = 33'(ent_q.pos) + 33'(nv_q);
    np_lo    = (np < 33'(lb_q)) ? 33'(lb_q) : np;
    np_clamp = (np_lo > 33'(ub_q)) ? ub_q : np_lo[ValW-1:0];
  end

  always_comb begin
    ent_new  = ent_q;
    rb_fit_d = rb_fit_q;
    rb_idx_d = rb_idx_q;
    rb_pos_d = rb_pos_q;
    case (req_q.action)
      ACT_LOAD: begin
        ent_new.pos = req_q.start_position;
        ent_new.vel = '0;
        ent_new.obf = FitMax;
      end
      ACT_FITNESS: begin
        ent_new.lat = req_q.fitness;
        if (req_ok_q && req_q.fitness < rb_fit_q) begin
          rb_fit_d = req_q.fitness;
          rb_idx_d = req_q.particle_index;
          rb_pos_d = ent_q.pos;
        end
      end
      ACT_MOVE: begin
        ent_new.vel = nv_q;
        ent_new.pos = np_clamp;
      end
      ACT_NEW_ROUND: begin
        rb_fit_d = FitMax;
      end
      default: ;
    endcase
    res_d.out_index     = req_q.particle_index;
    res_d.out_position  = req_ok_q ? ent_new.pos : '0;
    res_d.best_index    = rb_idx_d;
    res_d.best_position = rb_pos_d;
    res_d.best_fitness  = rb_fit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_fit_q <= FitMax;
      rb_idx_q <= '0;
      rb_pos_q <= '0;
    end else if (state_q == ST_WB) begin
      rb_fit_q <= rb_fit_d;
      rb_idx_q <= rb_idx_d;
      rb_pos_q <= rb_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WB) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= (state_q == ST_WB) ? res_d : res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== rtl/psu_checker.sv =====
// Port checker for the particle swarm update core and its bind statement.
module psu_checker
  import psu_pkg::*;
#(
  parameter int SWARM_SIZE = SwarmSizeDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // A stalled result word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // The core works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in progress");

  // A new result appears only at the end of processing, when the input is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared without processing");

  // A word for a particle outside the swarm reports a zero position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (32'(out_data_o.out_index) >= SWARM_SIZE) |-> out_data_o.out_position == '0)
    else $error("position reported for a particle outside the swarm");

endmodule

bind particle_swarm_update psu_checker #(.SWARM_SIZE(SWARM_SIZE)) u_psu_checker (.*);

// ===== bench/tb_particle_swarm_update.sv =====
// Self-checking testbench for the particle swarm update core with its own swarm predictor.
module tb_particle_swarm_update;
  import psu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class swarm_tracker;
    logic [GainW-1:0]       inertia, cog_gain, soc_gain;
    logic signed [ValW-1:0] pos_lo, pos_hi;
    logic signed [ValW-1:0] pos [SwarmSizeDef];
    logic signed [ValW-1:0] vel [SwarmSizeDef];
    logic signed [ValW-1:0] own_pos [SwarmSizeDef];
    logic signed [ValW-1:0] own_fit [SwarmSizeDef];
    logic signed [ValW-1:0] last_fit [SwarmSizeDef];
    bit                     loaded [SwarmSizeDef];
    bit                     fit_seen [SwarmSizeDef];
    bit                     own_pos_seen [SwarmSizeDef];
    logic signed [ValW-1:0] lead_fit, lead_pos;
    logic [IdxW-1:0]        lead_idx;
    out_word_t              awaited_q[$];
    int                     words_seen [4];
    int                     matched, mismatches;

    function new();
      inertia  = InertiaRst;
      cog_gain = CogGainRst;
      soc_gain = SocGainRst;
      pos_lo   = LowerRst;
      pos_hi   = UpperRst;
      lead_fit = FitMax;
      lead_idx = '0;
      lead_pos = '0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [ValW-1:0] d);
      case (r)
        CFG_INERTIA: inertia = d[GainW-1:0];
        CFG_COG:     cog_gain = d[GainW-1:0];
        CFG_SOC:     soc_gain = d[GainW-1:0];
        CFG_LOWER:   pos_lo = d;
        CFG_UPPER:   pos_hi = d;
        default:     ;
      endcase
    endfunction

    // Turns a word into one that never reads a particle entry that was never written.
    function in_word_t make_legal(in_word_t w);
      int i;
      i = w.particle_index;
      if (!loaded[i]) begin
        w.action = ACT_LOAD;
      end else if (w.action == ACT_MOVE &&
                   !(fit_seen[i] && (own_pos_seen[i] || last_fit[i] < own_fit[i]))) begin
        w.action = ACT_FITNESS;
      end
      return w;
    endfunction

    function void take_word(in_word_t w);
      int                     i;
      longint                 x, v, ob, gb, wt, a, b, k1, k2, acc, np;
      logic signed [ValW-1:0] nv;
      out_word_t              r;
      i = w.particle_index;
      words_seen[int'(w.action)]++;
      case (w.action)
        ACT_LOAD: begin
          pos[i] = w.start_position;
          vel[i] = '0;
          own_fit[i] = FitMax;
          loaded[i] = 1'b1;
        end
        ACT_FITNESS: begin
          last_fit[i] = w.fitness;
          fit_seen[i] = 1'b1;
          if (w.fitness < lead_fit) begin
            lead_fit = w.fitness;
            lead_idx = w.particle_index;
            lead_pos = pos[i];
          end
        end
        ACT_MOVE: begin
          if (last_fit[i] < own_fit[i]) begin
            own_fit[i] = last_fit[i];
            own_pos[i] = pos[i];
            own_pos_seen[i] = 1'b1;
          end
          x = pos[i];
          v = vel[i];
          ob = own_pos[i];
          gb = lead_pos;
          wt = inertia;
          a = w.rand_cognitive;
          b = cog_gain;
          k1 = (a * b) >>> 16;
          a = w.rand_social;
          b = soc_gain;
          k2 = (a * b) >>> 16;
          acc = (v * wt + (ob - x) * k1 + (gb - x) * k2) >>> 14;
          if (acc > 64'sd2147483647) begin
            nv = FitMax;
          end else if (acc < -64'sd2147483648) begin
            nv = 32'sh8000_0000;
          end else begin
            nv = acc[ValW-1:0];
          end
          vel[i] = nv;
          np = x + longint'(nv);
          if (np < longint'(pos_lo)) np = pos_lo;
          if (np > longint'(pos_hi)) np = pos_hi;
          pos[i] = np[ValW-1:0];
        end
        ACT_NEW_ROUND: lead_fit = FitMax;
        default: ;
      endcase
      r.out_index     = w.particle_index;
      r.out_position  = pos[i];
      r.best_index    = lead_idx;
      r.best_position = lead_pos;
      r.best_fitness  = lead_fit;
      awaited_q.push_back(r);
    endfunction

    function void check_result(out_word_t g);
      out_word_t e;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with none awaited: index %0d position %h", $realtime,
                   g.out_index, g.out_position);
        return;
      end
      e = awaited_q.pop_front();
      if (g.out_index !== e.out_index || g.out_position !== e.out_position ||
          g.best_index !== e.best_index || g.best_position !== e.best_position ||
          g.best_fitness !== e.best_fitness) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch (got/expected) index %0d/%0d position %h/%h ",
                    "best index %0d/%0d best position %h/%h best fitness %h/%h"}, $realtime,
                   g.out_index, e.out_index, g.out_position, e.out_position,
                   g.best_index, e.best_index, g.best_position, e.best_position,
                   g.best_fitness, e.best_fitness);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ValW-1:0]    cfg_data;

  swarm_tracker book;
  bit           idle_on;
  bit           hold_req;
  int           settings;

  particle_swarm_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 80;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) book.check_result(out_data);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic offer(input in_word_t w);
    int gap;
    w = book.make_legal(w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    book.take_word(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.awaited_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_put(input cfg_reg_e r, input logic [ValW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    book.set_reg(r, d);
    @(negedge clk_i);
  endtask

  function automatic in_word_t make_word(input action_e a, input int i,
                                         input logic [ValW-1:0] val,
                                         input logic [GainW-1:0] r1, r2);
    in_word_t w;
    w.action = a;
    w.particle_index = IdxW'(i);
    w.start_position = val;
    w.fitness = val;
    w.rand_cognitive = r1;
    w.rand_social = r2;
    return w;
  endfunction

  function automatic logic [GainW-1:0] random_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return GainW'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.particle_index = IdxW'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 12) w.action = ACT_LOAD;
    else if (pick < 50) w.action = ACT_FITNESS;
    else if (pick < 94) w.action = ACT_MOVE;
    else w.action = ACT_NEW_ROUND;
    if ($urandom_range(0, 1) == 0) w.start_position = $urandom;
    else w.start_position = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    if ($urandom_range(0, 2) == 0) w.fitness = $urandom;
    else w.fitness = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    w.rand_cognitive = random_fraction();
    w.rand_social = random_fraction();
    return w;
  endfunction

  task automatic run_phase(input logic [ValW-1:0] w, c1, c2, lo, hi, input int count,
                           input bit idle, input bit hold);
    drain();
    cfg_put(CFG_INERTIA, w);
    cfg_put(CFG_COG, c1);
    cfg_put(CFG_SOC, c2);
    cfg_put(CFG_LOWER, lo);
    cfg_put(CFG_UPPER, hi);
    cfg_valid <= 1'b0;
    settings++;
    idle_on = idle;
    if (hold) hold_req = 1'b1;
    repeat (count) offer(random_word());
  endtask

  initial begin
    book = new();
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_INERTIA;
    cfg_data = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    settings = 1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: extreme positions, ties on fitness, saturation and clamping.
    offer(make_word(ACT_LOAD, 0, 32'h0001_0000, 16'h1357, 16'h2468));
    offer(make_word(ACT_LOAD, 31, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000));
    offer(make_word(ACT_LOAD, 1, 32'h8000_0000, 16'h0000, 16'hFFFF));
    offer(make_word(ACT_NEW_ROUND, 0, 32'h5A5A_A5A5, 16'hA5A5, 16'h5A5A));
    offer(make_word(ACT_FITNESS, 0, 32'h7FFF_FFFF, 16'h0000, 16'h0000));
    offer(make_word(ACT_FITNESS, 31, 32'h8000_0000, 16'hFFFF, 16'hFFFF));
    offer(make_word(ACT_FITNESS, 1, 32'h0000_0000, 16'h8000, 16'h0001));
    offer(make_word(ACT_MOVE, 31, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    offer(make_word(ACT_MOVE, 1, 32'h0000_0000, 16'hFFFF, 16'hFFFF));
    offer(make_word(ACT_FITNESS, 0, 32'hFFFF_0000, 16'h0000, 16'h0000));
    offer(make_word(ACT_MOVE, 0, 32'h1234_5678, 16'h0000, 16'h0000));
    offer(make_word(ACT_NEW_ROUND, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    offer(make_word(ACT_FITNESS, 0, 32'h0000_0001, 16'h0F0F, 16'hF0F0));
    offer(make_word(ACT_LOAD, 30, 32'h0004_0000, 16'h0000, 16'h0000));
    offer(make_word(ACT_FITNESS, 30, 32'h0000_0002, 16'h0000, 16'h0000));
    offer(make_word(ACT_MOVE, 30, 32'h0000_0000, 16'h8000, 16'hFFFF));
    offer(make_word(ACT_MOVE, 30, 32'h0000_0000, 16'hFFFF, 16'h0000));
    offer(make_word(ACT_MOVE, 31, 32'h0000_0000, 16'h1234, 16'hABCD));
    offer(make_word(ACT_FITNESS, 1, 32'h8000_0000, 16'h0000, 16'h0000));
    offer(make_word(ACT_MOVE, 0, 32'h0000_0000, 16'hFFFF, 16'hFFFF));
    repeat (150) offer(random_word());

    run_phase(16384, 32768, 32768, 32'hFFC0_0000, 32'h0040_0000, 250, 1'b1, 1'b0);
    run_phase(0, 65535, 65535, 32'h8000_0000, 32'h7FFF_FFFF, 250, 1'b1, 1'b0);
    run_phase(65535, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 200, 1'b1, 1'b1);
    run_phase(6554, 16384, 16384, 32'h0010_0000, 32'hFFF0_0000, 150, 1'b0, 1'b0);
    run_phase(11469, 24576, 24576, 32'hFFF6_0000, 32'h000A_0000, 300, 1'b1, 1'b0);
    run_phase(1, 1, 65534, 32'h0001_2345, 32'h0001_2345, 150, 1'b1, 1'b0);
    run_phase(6554, 16384, 16384, 32'h0000_0000, 32'h0008_0000, 300, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (book.awaited_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Run covered %0d loads, %0d fitness reports, %0d moves and %0d new rounds",
             book.words_seen[ACT_LOAD], book.words_seen[ACT_FITNESS],
             book.words_seen[ACT_MOVE], book.words_seen[ACT_NEW_ROUND]);
    $display("under %0d register settings; %0d result words matched, %0d did not.",
             settings, book.matched, book.mismatches);
    if (book.mismatches == 0 && book.awaited_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/psu_pkg.sv
rtl/particle_swarm_update.sv
rtl/psu_checker.sv
bench/tb_particle_swarm_update.sv
